// ===== rtl/edcp_pkg.sv =====
// Package for the ed25519 certificate parser: item types, codes and parse state.
package edcp_pkg;

	localparam int KEY_BYTES_DEF      = 32;
	localparam int SIG_BYTES_DEF      = 64;
	localparam int MIN_BYTES_DEF      = 40;
	localparam int MAX_CERT_BYTES_DEF = 1024;

	// The byte count is 16 bits wide, which covers the largest certificate length.
	localparam int POS_W        = 16;
	localparam int KEY_TYPE_POS = 6;

	typedef enum logic [5:0] {
		PH_HEADER   = 6'b000001,
		PH_KEY      = 6'b000010,
		PH_COUNT    = 6'b000100,
		PH_EXT_HDR  = 6'b001000,
		PH_EXT_DATA = 6'b010000,
		PH_TRAIL    = 6'b100000
	} phase_t;

	typedef enum logic [2:0] {
		CLS_HEADER   = 3'd0,
		CLS_KEY      = 3'd1,
		CLS_COUNT    = 3'd2,
		CLS_EXT_HDR  = 3'd3,
		CLS_EXT_DATA = 3'd4,
		CLS_TRAIL    = 3'd5
	} class_t;

	typedef enum logic [2:0] {
		ST_OK        = 3'd0,
		ST_SHORT     = 3'd1,
		ST_VERSION   = 3'd2,
		ST_EXT_TRUNC = 3'd3,
		ST_SIG_SHORT = 3'd4
	} status_t;

	typedef struct packed {
		logic [7:0] cert_byte;
		logic       is_last_byte;
	} item_t;

	typedef struct packed {
		logic [2:0]  byte_class;
		logic [7:0]  extension_index;
		logic [7:0]  extension_type;
		logic [7:0]  extension_flags;
		logic [15:0] extension_length;
		logic        is_done;
		logic [2:0]  status;
		logic [7:0]  cert_version;
		logic [7:0]  cert_kind;
		logic [31:0] expiration_hours;
		logic [7:0]  key_type;
		logic [7:0]  extension_count;
	} result_t;

	typedef struct packed {
		logic [POS_W-1:0] pos;
		phase_t           phase;
		logic [7:0]       ext_left;
		logic [1:0]       hdr_cnt;
		logic [15:0]      data_left;
		logic [7:0]       version;
		logic [7:0]       ctype;
		logic [31:0]      expiry;
		logic [7:0]       key_type;
		logic [7:0]       ext_count;
		logic [15:0]      ext_length;
		logic [7:0]       ext_type;
		logic [7:0]       ext_flags;
	} parse_state_t;

	localparam parse_state_t STATE_RESET = '{
		pos:        '0,
		phase:      PH_HEADER,
		ext_left:   '0,
		hdr_cnt:    '0,
		data_left:  '0,
		version:    '0,
		ctype:      '0,
		expiry:     '0,
		key_type:   '0,
		ext_count:  '0,
		ext_length: '0,
		ext_type:   '0,
		ext_flags:  '0
	};

endpackage

// ===== rtl/edcp_step.sv =====
// Combinational parse step: next parse state and result for one certificate byte.
module edcp_step #(
	parameter int KEY_BYTES      = edcp_pkg::KEY_BYTES_DEF,
	parameter int SIG_BYTES      = edcp_pkg::SIG_BYTES_DEF,
	parameter int MIN_BYTES      = edcp_pkg::MIN_BYTES_DEF,
	parameter int MAX_CERT_BYTES = edcp_pkg::MAX_CERT_BYTES_DEF
) (
	input  edcp_pkg::parse_state_t st,
	input  edcp_pkg::item_t        item,
	output edcp_pkg::parse_state_t nxt,
	output edcp_pkg::result_t      res
);
	import edcp_pkg::*;

	localparam logic [POS_W-1:0] MAX_POS  = POS_W'(MAX_CERT_BYTES);
	localparam logic [POS_W-1:0] KEY_END  = POS_W'(KEY_TYPE_POS + KEY_BYTES);
	localparam logic [POS_W-1:0] MIN_LEN  = POS_W'(MIN_BYTES);
	localparam logic [POS_W-1:0] SIG_LEN  = POS_W'(SIG_BYTES);

	parse_state_t work;
	class_t       cls;
	status_t      status;
	logic         show_ext;
	logic [7:0]   b;

	always_comb begin
		work     = st;
		cls      = CLS_TRAIL;
		show_ext = 1'b0;
		status   = ST_OK;
		b        = item.cert_byte;

		// Beyond the length limit, bytes are classed trailing and the state stays put.
		if (st.pos < MAX_POS) begin
			case (st.phase)
				PH_HEADER: begin
					cls = CLS_HEADER;
					case (st.pos[2:0])
						3'd0: work.version = b;
						3'd1: work.ctype = b;
						3'd2: work.expiry[31:24] = b;
						3'd3: work.expiry[23:16] = b;
						3'd4: work.expiry[15:8] = b;
						3'd5: work.expiry[7:0] = b;
						default: begin
							work.key_type = b;
							work.phase    = PH_KEY;
						end
					endcase
				end
				PH_KEY: begin
					cls = CLS_KEY;
					if (st.pos >= KEY_END) begin
						work.phase = PH_COUNT;
					end
				end
				PH_COUNT: begin
					cls = CLS_COUNT;
					work.ext_count = b;
					if (b == 8'd0) begin
						work.phase = PH_TRAIL;
					end else begin
						work.ext_left = b;
						work.hdr_cnt  = 2'd0;
						work.phase    = PH_EXT_HDR;
					end
				end
				PH_EXT_HDR: begin
					cls      = CLS_EXT_HDR;
					show_ext = 1'b1;
					case (st.hdr_cnt)
						2'd0: begin
							work.ext_length = {b, 8'd0};
							work.ext_type   = 8'd0;
							work.ext_flags  = 8'd0;
						end
						2'd1: work.ext_length[7:0] = b;
						2'd2: work.ext_type = b;
						default: work.ext_flags = b;
					endcase
					if (st.hdr_cnt == 2'd3) begin
						work.data_left = work.ext_length;
						if (work.ext_length == 16'd0) begin
							work.ext_left = st.ext_left - 8'd1;
							work.hdr_cnt  = 2'd0;
							work.phase    = (work.ext_left == 8'd0) ? PH_TRAIL : PH_EXT_HDR;
						end else begin
							work.phase = PH_EXT_DATA;
						end
					end else begin
						work.hdr_cnt = st.hdr_cnt + 2'd1;
					end
				end
				PH_EXT_DATA: begin
					cls            = CLS_EXT_DATA;
					show_ext       = 1'b1;
					work.data_left = st.data_left - 16'd1;
					if (work.data_left == 16'd0) begin
						work.ext_left = st.ext_left - 8'd1;
						work.hdr_cnt  = 2'd0;
						work.phase    = (work.ext_left == 8'd0) ? PH_TRAIL : PH_EXT_HDR;
					end
				end
				default: cls = CLS_TRAIL;
			endcase
			work.pos = st.pos + POS_W'(1);
		end

		if (item.is_last_byte) begin
			if (work.pos < MIN_LEN) begin
				status = ST_SHORT;
			end else if (work.version == 8'd0) begin
				status = ST_VERSION;
			end else if (work.phase == PH_HEADER || work.phase == PH_KEY ||
				     work.phase == PH_COUNT) begin
				status = ST_SHORT;
			end else if (work.phase == PH_EXT_HDR || work.phase == PH_EXT_DATA) begin
				status = ST_EXT_TRUNC;
			end else if (work.pos < SIG_LEN) begin
				status = ST_SIG_SHORT;
			end else begin
				status = ST_OK;
			end
		end

		res.byte_class       = cls;
		res.extension_index  = show_ext ? (st.ext_count - st.ext_left) : 8'd0;
		res.extension_type   = show_ext ? work.ext_type : 8'd0;
		res.extension_flags  = show_ext ? work.ext_flags : 8'd0;
		res.extension_length = show_ext ? work.ext_length : 16'd0;
		res.is_done          = item.is_last_byte;
		res.status           = status;
		res.cert_version     = work.version;
		res.cert_kind        = work.ctype;
		res.expiration_hours = work.expiry;
		res.key_type         = work.key_type;
		res.extension_count  = work.ext_count;

		// After the final byte the parser starts afresh for the next certificate.
		nxt = item.is_last_byte ? STATE_RESET : work;
	end

endmodule

// ===== rtl/ed25519_certificate_parser.sv =====
// A byte accepted into the input register passes through the parse step into the result register.
// Throughput: one certificate byte per cycle, with results held while stalled.
// The input register and the result register are separate, so a byte can still be taken
// into an empty input register while a finished result waits downstream.
// Reset clears both valid flags and returns the parse state to the header phase.
// Top level of the streaming ed25519 certificate parser.
module ed25519_certificate_parser #(
	parameter int KEY_BYTES      = edcp_pkg::KEY_BYTES_DEF,
	parameter int SIG_BYTES      = edcp_pkg::SIG_BYTES_DEF,
	parameter int MIN_BYTES      = edcp_pkg::MIN_BYTES_DEF,
	parameter int MAX_CERT_BYTES = edcp_pkg::MAX_CERT_BYTES_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              item_valid,
	output logic              item_stall,
	input  edcp_pkg::item_t   item,
	output logic              result_valid,
	input  logic              result_stall,
	output edcp_pkg::result_t result
);
	import edcp_pkg::*;

	item_t        item_s1;
	logic         valid_s1;
	parse_state_t state_q;
	parse_state_t state_nxt;
	result_t      res_nxt;
	result_t      result_q;
	logic         result_valid_q;
	logic         advance;

	edcp_step #(
		.KEY_BYTES      (KEY_BYTES),
		.SIG_BYTES      (SIG_BYTES),
		.MIN_BYTES      (MIN_BYTES),
		.MAX_CERT_BYTES (MAX_CERT_BYTES)
	) u_step (
		.st   (state_q),
		.item (item_s1),
		.nxt  (state_nxt),
		.res  (res_nxt)
	);

	assign advance    = valid_s1 && (!result_valid_q || !result_stall);
	assign item_stall = valid_s1 && !advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1       <= 1'b0;
			result_valid_q <= 1'b0;
			state_q        <= STATE_RESET;
		end else begin
			if (!item_stall) begin
				valid_s1 <= item_valid;
			end
			if (advance) begin
				result_valid_q <= 1'b1;
				state_q        <= state_nxt;
			end else if (!result_stall) begin
				result_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (!item_stall && item_valid) begin
			item_s1 <= item;
		end
		if (advance) begin
			result_q <= res_nxt;
		end
	end

	assign result_valid = result_valid_q;
	assign result       = result_q;

endmodule

// ===== rtl/edcp_checker.sv =====
// Port-level checker for the certificate parser, bound to the top level.
module edcp_checker (
	input logic              clk,
	input logic              arst_n,
	input logic              result_valid,
	input logic              result_stall,
	input edcp_pkg::result_t result
);
	import edcp_pkg::*;

	// A transaction held back by the consumer stays unchanged.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_stall |=> result_valid && $stable(result))
		else $error("result changed while stalled");

	// Status is reported only on the final byte of a certificate.
	a_status_done: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result.is_done |-> result.status == ST_OK)
		else $error("status reported before the final byte");

	// Extension fields are zero outside extension headers and data.
	a_ext_zero: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result.byte_class != CLS_EXT_HDR &&
		result.byte_class != CLS_EXT_DATA |->
		result.extension_index == 8'd0 && result.extension_length == 16'd0 &&
		result.extension_type == 8'd0 && result.extension_flags == 8'd0)
		else $error("extension fields set outside an extension");

	// The extension count is not yet known while the header is being read.
	a_hdr_count: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result.byte_class == CLS_HEADER |->
		result.extension_count == 8'd0)
		else $error("extension count set during header");

endmodule

bind ed25519_certificate_parser edcp_checker u_edcp_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.result_valid (result_valid),
	.result_stall (result_stall),
	.result       (result)
);

// ===== test/tb.sv =====
// Self-checking testbench for the streaming ed25519 certificate parser.
`timescale 1ns / 1ps

module tb;
	import edcp_pkg::*;

	typedef enum int {
		FILL_RAND,
		FILL_ZERO,
		FILL_ONES
	} fill_t;

	typedef struct {
		int         len;
		logic [7:0] ver;
		int         n_ext;
		int         ext_len;
		fill_t      fill;
		status_t    st;
	} cert_case_t;

	// Each row is one certificate; its status on the final byte is typed in.
	cert_case_t cert_cases [13] = '{
		'{1,    8'h01, 0,   0,     FILL_RAND, ST_SHORT},
		'{39,   8'h01, 0,   0,     FILL_ONES, ST_SHORT},
		'{30,   8'h00, 0,   0,     FILL_ZERO, ST_SHORT},
		'{40,   8'h00, 0,   0,     FILL_ZERO, ST_VERSION},
		'{40,   8'h01, 0,   0,     FILL_RAND, ST_SIG_SHORT},
		'{64,   8'hFF, 0,   0,     FILL_ONES, ST_OK},
		'{104,  8'h01, 1,   0,     FILL_ZERO, ST_OK},
		'{42,   8'h01, 1,   5,     FILL_RAND, ST_EXT_TRUNC},
		'{50,   8'h01, 1,   20,    FILL_RAND, ST_EXT_TRUNC},
		'{48,   8'h01, 1,   65535, FILL_ONES, ST_EXT_TRUNC},
		'{64,   8'h01, 1,   20,    FILL_RAND, ST_OK},
		'{70,   8'h80, 2,   3,     FILL_ONES, ST_OK},
		'{1030, 8'h01, 255, 0,     FILL_ZERO, ST_EXT_TRUNC}
	};

	logic    clk = 1'b0;
	logic    arst_n = 1'b0;
	logic    item_valid = 1'b0;
	logic    item_stall;
	item_t   item = '0;
	logic    result_valid;
	logic    result_stall = 1'b0;
	result_t result;

	int send_idle_pct = 29;
	int recv_idle_pct = 50;

	logic [7:0] cert_bytes[$];
	result_t    expected_results[$];
	result_t    want_r;

	int mismatches = 0;
	int results_checked = 0;
	int bytes_sent = 0;
	int certs_sent = 0;
	int status_seen [8];

	// Parse state mirrored from the block.
	logic [15:0] cur_pos = '0;
	phase_t      cur_phase = PH_HEADER;
	logic [7:0]  cur_ext_left = '0;
	logic [1:0]  cur_hdr_cnt = '0;
	logic [15:0] cur_data_left = '0;
	logic [7:0]  cur_version = '0;
	logic [7:0]  cur_ctype = '0;
	logic [31:0] cur_expiry = '0;
	logic [7:0]  cur_key_type = '0;
	logic [7:0]  cur_ext_count = '0;
	logic [15:0] cur_ext_length = '0;
	logic [7:0]  cur_ext_type = '0;
	logic [7:0]  cur_ext_flags = '0;

	ed25519_certificate_parser u_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_stall   (item_stall),
		.item         (item),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	function automatic void close_extension();
		cur_ext_left = cur_ext_left - 8'd1;
		cur_hdr_cnt = '0;
		cur_phase = (cur_ext_left == 8'd0) ? PH_TRAIL : PH_EXT_HDR;
	endfunction

	function automatic result_t parse_byte(input logic [7:0] b, input logic last);
		result_t r;
		int      p;
		r = '0;
		p = cur_pos;
		r.byte_class = CLS_TRAIL;
		if (p < MAX_CERT_BYTES_DEF) begin
			case (cur_phase)
			PH_HEADER: begin
				r.byte_class = CLS_HEADER;
				if (p == 0)
					cur_version = b;
				else if (p == 1)
					cur_ctype = b;
				else if (p <= 5)
					cur_expiry[8 * (5 - p) +: 8] = b;
				else begin
					cur_key_type = b;
					cur_phase = PH_KEY;
				end
			end
			PH_KEY: begin
				r.byte_class = CLS_KEY;
				if (p >= KEY_TYPE_POS + KEY_BYTES_DEF)
					cur_phase = PH_COUNT;
			end
			PH_COUNT: begin
				r.byte_class = CLS_COUNT;
				cur_ext_count = b;
				if (b == 8'd0)
					cur_phase = PH_TRAIL;
				else begin
					cur_ext_left = b;
					cur_hdr_cnt = '0;
					cur_phase = PH_EXT_HDR;
				end
			end
			PH_EXT_HDR: begin
				r.byte_class = CLS_EXT_HDR;
				r.extension_index = cur_ext_count - cur_ext_left;
				case (cur_hdr_cnt)
				2'd0: begin
					cur_ext_length = {b, 8'h00};
					cur_ext_type = '0;
					cur_ext_flags = '0;
				end
				2'd1: cur_ext_length[7:0] = b;
				2'd2: cur_ext_type = b;
				default: cur_ext_flags = b;
				endcase
				r.extension_type = cur_ext_type;
				r.extension_flags = cur_ext_flags;
				r.extension_length = cur_ext_length;
				if (cur_hdr_cnt == 2'd3) begin
					cur_data_left = cur_ext_length;
					if (cur_data_left == 16'd0)
						close_extension();
					else
						cur_phase = PH_EXT_DATA;
				end else
					cur_hdr_cnt = cur_hdr_cnt + 2'd1;
			end
			PH_EXT_DATA: begin
				r.byte_class = CLS_EXT_DATA;
				r.extension_index = cur_ext_count - cur_ext_left;
				r.extension_type = cur_ext_type;
				r.extension_flags = cur_ext_flags;
				r.extension_length = cur_ext_length;
				cur_data_left = cur_data_left - 16'd1;
				if (cur_data_left == 16'd0)
					close_extension();
			end
			default: r.byte_class = CLS_TRAIL;
			endcase
			cur_pos = cur_pos + 16'd1;
		end

		if (last) begin
			r.is_done = 1'b1;
			if (cur_pos < MIN_BYTES_DEF)
				r.status = ST_SHORT;
			else if (cur_version == 8'd0)
				r.status = ST_VERSION;
			else if (cur_phase == PH_HEADER || cur_phase == PH_KEY || cur_phase == PH_COUNT)
				r.status = ST_SHORT;
			else if (cur_phase == PH_EXT_HDR || cur_phase == PH_EXT_DATA)
				r.status = ST_EXT_TRUNC;
			else if (cur_pos < SIG_BYTES_DEF)
				r.status = ST_SIG_SHORT;
			else
				r.status = ST_OK;
		end
		r.cert_version = cur_version;
		r.cert_kind = cur_ctype;
		r.expiration_hours = cur_expiry;
		r.key_type = cur_key_type;
		r.extension_count = cur_ext_count;

		if (last) begin
			cur_pos = '0;
			cur_phase = PH_HEADER;
			cur_ext_left = '0;
			cur_hdr_cnt = '0;
			cur_data_left = '0;
			cur_version = '0;
			cur_ctype = '0;
			cur_expiry = '0;
			cur_key_type = '0;
			cur_ext_count = '0;
			cur_ext_length = '0;
			cur_ext_type = '0;
			cur_ext_flags = '0;
		end
		return r;
	endfunction

	function automatic logic [7:0] filler(input fill_t f);
		case (f)
		FILL_ZERO: return 8'h00;
		FILL_ONES: return 8'hFF;
		default: return 8'($urandom_range(255));
		endcase
	endfunction

	function automatic void add_byte(input logic [7:0] v);
		cert_bytes.insert(cert_bytes.size(), v);
	endfunction

	// A negative length asks for the natural length of the structure plus some trailing bytes;
	// a negative extension length draws one per extension.
	task automatic build_cert(input int len, input logic [7:0] ver, input int n_ext,
			input int ext_len, input fill_t fill);
		int k;
		int j;
		int dlen;
		int target;
		cert_bytes.delete();
		add_byte(ver);
		for (k = 1; k <= KEY_TYPE_POS + KEY_BYTES_DEF; k++)
			add_byte(filler(fill));
		add_byte(8'(n_ext));
		for (k = 0; k < n_ext && (len < 0 || cert_bytes.size() < len); k++) begin
			if (ext_len >= 0)
				dlen = ext_len;
			else if (len >= 0 && $urandom_range(3) == 0)
				dlen = $urandom_range(65535);
			else
				dlen = $urandom_range(12);
			add_byte(8'(dlen >> 8));
			add_byte(8'(dlen));
			add_byte(filler(fill));
			add_byte(filler(fill));
			for (j = 0; j < dlen && (len < 0 || cert_bytes.size() < len); j++)
				add_byte(filler(fill));
		end
		target = len;
		if (len < 0) begin
			target = cert_bytes.size() + $urandom_range(40);
			if ($urandom_range(3) != 0 && target < SIG_BYTES_DEF)
				target = SIG_BYTES_DEF + $urandom_range(8);
		end
		while (cert_bytes.size() < target)
			add_byte(filler(fill));
		while (cert_bytes.size() > target)
			void'(cert_bytes.pop_back());
	endtask

	task automatic send_byte(input logic [7:0] b, input logic last, input bit typed,
			input status_t want_status);
		result_t r;
		if ($urandom_range(99) < send_idle_pct) begin
			item_valid <= 1'b0;
			do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
		end
		item_valid <= 1'b1;
		item <= '{cert_byte: b, is_last_byte: last};
		do @(posedge clk); while (item_stall);
		r = parse_byte(b, last);
		if (last && typed)
			r.status = want_status;
		expected_results.insert(expected_results.size(), r);
		bytes_sent++;
	endtask

	task automatic send_cert(input bit typed, input status_t want_status);
		foreach (cert_bytes[i])
			send_byte(cert_bytes[i], i == cert_bytes.size() - 1, typed, want_status);
		certs_sent++;
	endtask

	task automatic check_field(input string name, input logic [31:0] want, input logic [31:0] got);
		if (want !== got) begin
			$display("%0t: %s expected %0h, actual %0h", $time, name, want, got);
			mismatches++;
		end
	endtask

	// Each accepted result transaction is checked against the oldest prediction.
	always @(posedge clk) begin
		if (arst_n && result_valid && !result_stall) begin
			if (expected_results.size() == 0) begin
				$display("%0t: result expected none, actual %h", $time, result);
				mismatches++;
			end else begin
				want_r = expected_results.pop_front();
				check_field("byte_class", want_r.byte_class, result.byte_class);
				check_field("extension_index", want_r.extension_index, result.extension_index);
				check_field("extension_type", want_r.extension_type, result.extension_type);
				check_field("extension_flags", want_r.extension_flags, result.extension_flags);
				check_field("extension_length", want_r.extension_length,
					result.extension_length);
				check_field("is_done", want_r.is_done, result.is_done);
				check_field("status", want_r.status, result.status);
				check_field("cert_version", want_r.cert_version, result.cert_version);
				check_field("cert_kind", want_r.cert_kind, result.cert_kind);
				check_field("expiration_hours", want_r.expiration_hours,
					result.expiration_hours);
				check_field("key_type", want_r.key_type, result.key_type);
				check_field("extension_count", want_r.extension_count, result.extension_count);
				if (result.is_done)
					status_seen[result.status]++;
				results_checked++;
			end
		end
		result_stall <= ($urandom_range(99) < recv_idle_pct);
	end

	initial begin
		int         rand_bytes;
		int         sel;
		logic [7:0] ver;
		rand_bytes = 0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;

		foreach (cert_cases[i]) begin
			build_cert(cert_cases[i].len, cert_cases[i].ver, cert_cases[i].n_ext,
				cert_cases[i].ext_len, cert_cases[i].fill);
			send_cert(1'b1, cert_cases[i].st);
		end

		// Hold off until the parser has drained completely.
		item_valid <= 1'b0;
		do @(posedge clk); while (expected_results.size() != 0);

		while (rand_bytes < 800) begin
			if (rand_bytes >= 533) begin
				send_idle_pct = 0;
				recv_idle_pct = 0;
			end else if (rand_bytes >= 266) begin
				send_idle_pct = 50;
				recv_idle_pct = 29;
			end
			sel = $urandom_range(99);
			ver = ($urandom_range(9) == 0) ? 8'h00 : 8'($urandom_range(255, 1));
			if (sel < 70)
				build_cert(-1, ver, $urandom_range(4), -1, FILL_RAND);
			else if (sel < 85)
				build_cert($urandom_range(120, 1), ver, $urandom_range(4), -1, FILL_RAND);
			else
				build_cert($urandom_range(60, 1), 8'($urandom_range(255)), $urandom_range(255),
					-1, FILL_RAND);
			rand_bytes += cert_bytes.size();
			send_cert(1'b0, ST_OK);
		end

		item_valid <= 1'b0;
		do @(posedge clk); while (expected_results.size() != 0);
		repeat (4) @(posedge clk);

		$display("Sent %0d certificates as %0d bytes; %0d results checked.",
			certs_sent, bytes_sent, results_checked);
		$display("Final statuses: ok %0d, short %0d, version %0d, truncated %0d, sig short %0d.",
			status_seen[ST_OK], status_seen[ST_SHORT], status_seen[ST_VERSION],
			status_seen[ST_EXT_TRUNC], status_seen[ST_SIG_SHORT]);
		if (mismatches == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

	initial begin
		#2000000;
		$display("Timed out waiting for the parser.");
		$display("Mismatches found");
		$finish;
	end

endmodule
